[hw/rtl/npcs_pkg.sv]
package npcs_pkg;

	localparam int unsigned PALETTE_ENTRIES_DEF = 256;
	localparam int unsigned INDEX_W = 8;
	localparam int unsigned CHAN_W = 8;
	localparam int unsigned DIST_W = 18;
	localparam logic [DIST_W-1:0] MAX_DIST = 18'd195075;

	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [INDEX_W-1:0] entry_index;
		logic [CHAN_W-1:0]  red;
		logic [CHAN_W-1:0]  green;
		logic [CHAN_W-1:0]  blue;
	} in_item_t;

	typedef struct packed {
		logic [INDEX_W-1:0] best_index;
		logic [DIST_W-1:0]  best_distance;
	} out_item_t;

	// what moves from one cell to the next
	typedef struct packed {
		logic               valid;
		in_item_t           item;
		logic [INDEX_W-1:0] best_index;
		logic [DIST_W-1:0]  best_distance;
	} link_t;

endpackage

[hw/rtl/npcs_cell.sv]
module npcs_cell import npcs_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  advance,
	input  link_t prev,
	output link_t next
);

	logic [CHAN_W-1:0] red_q, green_q, blue_q;
	logic              valid_q;
	in_item_t          item_q;
	logic [INDEX_W-1:0] best_index_q;
	logic [DIST_W-1:0]  best_distance_q;

	logic [CHAN_W-1:0]   diff_r, diff_g, diff_b;
	logic [2*CHAN_W-1:0] sq_r, sq_g, sq_b;
	logic [DIST_W-1:0]   dist_sum;
	logic                take;
	logic                wr_hit;

	always_comb begin
		diff_r = (red_q > prev.item.red) ? red_q - prev.item.red : prev.item.red - red_q;
		diff_g = (green_q > prev.item.green) ? green_q - prev.item.green
			: prev.item.green - green_q;
		diff_b = (blue_q > prev.item.blue) ? blue_q - prev.item.blue
			: prev.item.blue - blue_q;
		sq_r = {{CHAN_W{1'b0}}, diff_r} * {{CHAN_W{1'b0}}, diff_r};
		sq_g = {{CHAN_W{1'b0}}, diff_g} * {{CHAN_W{1'b0}}, diff_g};
		sq_b = {{CHAN_W{1'b0}}, diff_b} * {{CHAN_W{1'b0}}, diff_b};
		dist_sum = DIST_W'(sq_r) + DIST_W'(sq_g) + DIST_W'(sq_b);
		// first cell always takes its entry; later ones only on a strict win
		take = (IDX == 0) || (dist_sum < prev.best_distance);
		wr_hit = advance && prev.valid && (prev.item.kind == KIND_WRITE)
			&& (prev.item.entry_index == INDEX_W'(IDX));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			valid_q <= 1'b0;
		end else begin
			if (wr_hit) begin
				red_q   <= prev.item.red;
				green_q <= prev.item.green;
				blue_q  <= prev.item.blue;
			end
			if (advance) begin
				valid_q <= prev.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			item_q <= prev.item;
			if (take) begin
				best_index_q    <= INDEX_W'(IDX);
				best_distance_q <= dist_sum;
			end else begin
				best_index_q    <= prev.best_index;
				best_distance_q <= prev.best_distance;
			end
		end
	end

	assign next.valid         = valid_q;
	assign next.item          = item_q;
	assign next.best_index    = best_index_q;
	assign next.best_distance = best_distance_q;

endmodule

[hw/rtl/nearest_palette_color_search_top.sv]
// Nearest palette color search. Each palette entry lives in its own cell of a chain of
// PALETTE_ENTRIES cells; every item (write or query) walks the chain one cell per cycle
// unless the chain stalls, so one item is accepted per clock while item_ready is high.
// A query loads the first cell on the edge that accepts it, moves through each later
// cell in turn and is then loaded into the output register from the last cell. A write
// lands in its cell on the way through, so it affects exactly the queries accepted after it.
// Writes to an entry at or above PALETTE_ENTRIES pass through and change nothing. Reset
// clears all entries to black at once; no clearing pass is needed. The chain only stalls
// when a query reaches its end while the previous result has not been taken.
module nearest_palette_color_search_top import npcs_pkg::*; #(
	parameter int unsigned PALETTE_ENTRIES = PALETTE_ENTRIES_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      item_valid,
	output logic      item_ready,
	input  in_item_t  item,
	output logic      result_valid,
	input  logic      result_ready,
	output out_item_t result
);

	link_t     link [0:PALETTE_ENTRIES];
	logic      advance;
	logic      tail_query;
	logic      result_valid_q;
	out_item_t result_q;

	assign link[0].valid         = item_valid;
	assign link[0].item          = item;
	assign link[0].best_index    = '0;
	assign link[0].best_distance = '0;

	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
		npcs_cell #(
			.IDX (k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.prev    (link[k]),
			.next    (link[k+1])
		);
	end

	assign tail_query = link[PALETTE_ENTRIES].valid
		&& (link[PALETTE_ENTRIES].item.kind == KIND_QUERY);
	// writes just fall off the end, only a query can block the chain
	assign advance    = !(tail_query && result_valid_q && !result_ready);
	assign item_ready = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && tail_query) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && tail_query) begin
			result_q.best_index    <= link[PALETTE_ENTRIES].best_index;
			result_q.best_distance <= link[PALETTE_ENTRIES].best_distance;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_tail_to_output: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && tail_query) |=> result_valid)
		else $error("query leaving the chain did not reach the output");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (32'(result.best_index) < PALETTE_ENTRIES))
		else $error("best index beyond the palette");

	a_distance_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.best_distance <= MAX_DIST))
		else $error("best distance out of range");

endmodule
